// File: design/cnw_pkg.sv
`timescale 1ns / 1ps

package cnw_pkg;

    // sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_POWERUP    = 3'd1,
        PH_EN_HIGH    = 3'd2,
        PH_GAP        = 3'd3,
        PH_CLEAR_WAIT = 3'd4
    } phase_t;

    // request kinds after decode
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_CMD  = 2'd1,
        OP_DATA = 2'd2,
        OP_INIT = 2'd3
    } op_t;

    // one decoded word passed from the front to the back
    typedef struct packed {
        op_t        op;
        logic [7:0] byte_val;
    } req_t;

    // register map, word index
    localparam logic [1:0] REG_EN_HIGH  = 2'd0;
    localparam logic [1:0] REG_GAP      = 2'd1;
    localparam logic [1:0] REG_POWERUP  = 2'd2;
    localparam logic [1:0] REG_CLEAR    = 2'd3;

    // register reset values
    localparam logic [7:0]  EN_HIGH_RST = 8'd1;
    localparam logic [11:0] GAP_RST     = 12'd100;
    localparam logic [15:0] POWERUP_RST = 16'd3000;
    localparam logic [15:0] CLEAR_RST   = 16'd2000;

    // init sequence bookkeeping
    localparam logic [2:0] STEP_NONE  = 3'd0;
    localparam logic [2:0] STEP_FIRST = 3'd1;
    localparam logic [2:0] STEP_CLEAR = 3'd5;
    localparam logic [2:0] STEP_LAST  = 3'd6;

    localparam logic [7:0] CMD_WAKE_A    = 8'h33;
    localparam logic [7:0] CMD_WAKE_B    = 8'h32;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;

    // init byte by zero-based position in the sequence
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0:    b = CMD_WAKE_A;
            3'd1:    b = CMD_WAKE_B;
            3'd2:    b = CMD_FUNC_SET;
            3'd3:    b = CMD_DISP_ON;
            3'd4:    b = CMD_CLEAR;
            default: b = CMD_ENTRY;
        endcase
        return b;
    endfunction

    // a duration of zero counts as one tick
    function automatic logic [15:0] at_least_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

endpackage

// File: design/cnw_front.sv
`timescale 1ns / 1ps

module cnw_front
    import cnw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_byte_in,
    output logic       q_valid,
    output req_t       q_req,
    input  logic       q_pop
);

    localparam int DEPTH = 2;

    req_t       mem_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    req_t       in_req;
    logic       push;
    logic       pop;

    // classify the incoming word
    always_comb begin
        in_req.byte_val = s_byte_in;
        unique case (s_opcode)
            OP_CMD:  in_req.op = OP_CMD;
            OP_DATA: in_req.op = OP_DATA;
            OP_INIT: in_req.op = OP_INIT;
            default: in_req.op = OP_TICK;
        endcase
    end

    assign s_ready = (count_reg != 2'(DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign pop     = q_pop && q_valid;
    assign q_req   = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

// File: design/cnw_back.sv
`timescale 1ns / 1ps

module cnw_back
    import cnw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  req_t        q_req,
    output logic        q_pop,
    input  logic [7:0]  en_high_ticks,
    input  logic [11:0] nibble_gap_ticks,
    input  logic [15:0] powerup_wait_ticks,
    input  logic [15:0] clear_wait_ticks,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_data_nibble,
    output logic        m_reg_select,
    output logic        m_enable_line,
    output logic        m_busy_res,
    output logic        m_rejected
);

    phase_t      phase_reg, phase_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [7:0]  held_reg, held_next;
    logic        rs_reg, rs_next;
    logic        low_reg, low_next;
    logic [2:0]  step_reg, step_next;
    logic [3:0]  nib_reg, nib_next;

    logic        m_valid_reg, m_valid_next;
    logic [3:0]  nib_out_reg, nib_out_next;
    logic        rs_out_reg, rs_out_next;
    logic        en_out_reg, en_out_next;
    logic        busy_out_reg, busy_out_next;
    logic        rej_out_reg, rej_out_next;

    logic        step_en;
    logic        start_init;
    logic [7:0]  start_val;
    logic [15:0] en_dur;

    // take the next word whenever the output slot is free or draining
    assign step_en = q_valid && (!m_valid_reg || m_ready);
    assign q_pop   = step_en;
    assign en_dur  = at_least_one({8'd0, en_high_ticks});

    // one tick: accept a request, snapshot the lines, then count down
    always_comb begin
        phase_next    = phase_reg;
        cnt_next      = cnt_reg;
        held_next     = held_reg;
        rs_next       = rs_reg;
        low_next      = low_reg;
        step_next     = step_reg;
        nib_next      = nib_reg;
        rej_out_next  = 1'b0;
        start_init    = 1'b0;
        start_val     = CMD_ENTRY;

        // request handling
        if (q_req.op != OP_TICK) begin
            if (phase_reg != PH_IDLE) begin
                rej_out_next = 1'b1;
            end else begin
                unique case (q_req.op)
                    OP_CMD, OP_DATA: begin
                        step_next  = STEP_NONE;
                        held_next  = q_req.byte_val;
                        rs_next    = (q_req.op == OP_DATA);
                        low_next   = 1'b0;
                        nib_next   = q_req.byte_val[7:4];
                        phase_next = PH_EN_HIGH;
                        cnt_next   = en_dur;
                    end
                    OP_INIT: begin
                        step_next  = STEP_NONE;
                        phase_next = PH_POWERUP;
                        cnt_next   = at_least_one(powerup_wait_ticks);
                    end
                    default: ;
                endcase
            end
        end

        // line levels seen during this tick
        nib_out_next  = nib_next;
        rs_out_next   = rs_next;
        en_out_next   = (phase_next == PH_EN_HIGH);
        busy_out_next = (phase_next != PH_IDLE);

        // countdown and phase advance
        if (phase_next != PH_IDLE) begin
            if (cnt_next > 16'd1) begin
                cnt_next = cnt_next - 16'd1;
            end else begin
                cnt_next = 16'd0;
                unique case (phase_next)
                    PH_POWERUP: begin
                        step_next  = STEP_FIRST;
                        start_init = 1'b1;
                        start_val  = CMD_WAKE_A;
                    end
                    PH_EN_HIGH: begin
                        phase_next = PH_GAP;
                        cnt_next   = at_least_one({4'd0, nibble_gap_ticks});
                    end
                    PH_GAP: begin
                        if (!low_next) begin
                            low_next   = 1'b1;
                            nib_next   = held_next[3:0];
                            phase_next = PH_EN_HIGH;
                            cnt_next   = en_dur;
                        end else begin
                            priority if (step_next == STEP_CLEAR) begin
                                phase_next = PH_CLEAR_WAIT;
                                cnt_next   = at_least_one(clear_wait_ticks);
                            end else if (step_next == STEP_NONE || step_next >= STEP_LAST) begin
                                step_next  = STEP_NONE;
                                phase_next = PH_IDLE;
                            end else begin
                                start_init = 1'b1;
                                start_val  = init_byte(step_next);
                                step_next  = step_next + 3'd1;
                            end
                        end
                    end
                    PH_CLEAR_WAIT: begin
                        step_next  = STEP_LAST;
                        start_init = 1'b1;
                        start_val  = CMD_ENTRY;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end

        // launch of an init byte, always a command
        if (start_init) begin
            held_next  = start_val;
            rs_next    = 1'b0;
            low_next   = 1'b0;
            nib_next   = start_val[7:4];
            phase_next = PH_EN_HIGH;
            cnt_next   = en_dur;
        end

        m_valid_next = step_en ? 1'b1 : (m_valid_reg && !m_ready);
    end

    // sequencer state and output word valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= 16'd0;
            held_reg    <= 8'd0;
            rs_reg      <= 1'b0;
            low_reg     <= 1'b0;
            step_reg    <= STEP_NONE;
            nib_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (step_en) begin
                phase_reg <= phase_next;
                cnt_reg   <= cnt_next;
                held_reg  <= held_next;
                rs_reg    <= rs_next;
                low_reg   <= low_next;
                step_reg  <= step_next;
                nib_reg   <= nib_next;
            end
        end
    end

    // output word payload
    always_ff @(posedge aclk) begin
        if (step_en) begin
            nib_out_reg  <= nib_out_next;
            rs_out_reg   <= rs_out_next;
            en_out_reg   <= en_out_next;
            busy_out_reg <= busy_out_next;
            rej_out_reg  <= rej_out_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_data_nibble = nib_out_reg;
    assign m_reg_select  = rs_out_reg;
    assign m_enable_line = en_out_reg;
    assign m_busy_res    = busy_out_reg;
    assign m_rejected    = rej_out_reg;

endmodule

// File: design/char_lcd_nibble_writer.sv
`timescale 1ns / 1ps

// Character display controller for a 4-bit HD44780-style bus. Every input word
// is one microsecond tick and may carry a request (tick only, command byte,
// data byte, or the power-up init sequence); every input word yields exactly
// one output word giving the RS, EN and D4..D7 levels for that tick, plus
// busy and rejected flags. A byte goes out high nibble first, each nibble
// with EN high for en_high_ticks and then low for nibble_gap_ticks; a request
// that arrives while busy is dropped and flagged. Throughput is one word per
// clock while the output is not stalled: a two-word queue sits between the
// decode front and the sequencer, and the sequencer advances its tick counter
// once per word. Durations are set over the APB port (0x0 enable-high, 0x4
// nibble gap, 0x8 power-up wait, 0xC clear wait); a duration of zero acts as
// one. Write them only while the block is idle.
module char_lcd_nibble_writer
    import cnw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_byte_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_data_nibble,
    output logic        m_reg_select,
    output logic        m_enable_line,
    output logic        m_busy_res,
    output logic        m_rejected
);

    logic [7:0]  en_high_reg;
    logic [11:0] gap_reg;
    logic [15:0] powerup_reg;
    logic [15:0] clear_reg;
    logic        cfg_wr;
    logic        q_valid;
    logic        q_pop;
    req_t        q_req;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_high_reg <= EN_HIGH_RST;
            gap_reg     <= GAP_RST;
            powerup_reg <= POWERUP_RST;
            clear_reg   <= CLEAR_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_EN_HIGH: en_high_reg <= pwdata[7:0];
                REG_GAP:     gap_reg     <= pwdata[11:0];
                REG_POWERUP: powerup_reg <= pwdata[15:0];
                REG_CLEAR:   clear_reg   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (paddr[3:2])
            REG_EN_HIGH: prdata = {24'd0, en_high_reg};
            REG_GAP:     prdata = {20'd0, gap_reg};
            REG_POWERUP: prdata = {16'd0, powerup_reg};
            REG_CLEAR:   prdata = {16'd0, clear_reg};
            default:     prdata = 32'd0;
        endcase
    end

    cnw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .s_byte_in (s_byte_in),
        .q_valid   (q_valid),
        .q_req     (q_req),
        .q_pop     (q_pop)
    );

    cnw_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_req              (q_req),
        .q_pop              (q_pop),
        .en_high_ticks      (en_high_reg),
        .nibble_gap_ticks   (gap_reg),
        .powerup_wait_ticks (powerup_reg),
        .clear_wait_ticks   (clear_reg),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data_nibble      (m_data_nibble),
        .m_reg_select       (m_reg_select),
        .m_enable_line      (m_enable_line),
        .m_busy_res         (m_busy_res),
        .m_rejected         (m_rejected)
    );

endmodule

// File: design/cnw_checker.sv
`timescale 1ns / 1ps

module cnw_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       pready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [3:0] m_data_nibble,
    input logic       m_enable_line,
    input logic       m_busy_res,
    input logic       m_rejected
);

    // output channel empties on reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid after reset");

    // enable strobe only inside a busy transfer
    a_en_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_enable_line) |-> m_busy_res)
        else $error("enable high while not busy");

    // a dropped request implies the sequencer was busy
    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rejected) |-> m_busy_res)
        else $error("request rejected while idle");

    // stalled output word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data_nibble)))
        else $error("stalled output word changed");

    // configuration port never stalls
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind char_lcd_nibble_writer cnw_checker u_cnw_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .pready        (pready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_data_nibble (m_data_nibble),
    .m_enable_line (m_enable_line),
    .m_busy_res    (m_busy_res),
    .m_rejected    (m_rejected)
);

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench
    import cnw_pkg::*;
();

    localparam int CYCLE_LIMIT   = 2000000;
    localparam int DRAIN_CYCLES  = 4;
    localparam int RANDOM_WORDS  = 700;
    // init commands packed lowest first, byte k sits at [8*k +: 8]
    localparam logic [47:0] INIT_CMDS = {CMD_ENTRY, CMD_CLEAR, CMD_DISP_ON,
                                         CMD_FUNC_SET, CMD_WAKE_B, CMD_WAKE_A};

    // line levels and flags for one tick
    typedef struct packed {
        logic [3:0] nibble;
        logic       rs;
        logic       en;
        logic       busy;
        logic       rej;
    } lcd_levels_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [7:0]  s_byte_in;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_data_nibble;
    logic        m_reg_select;
    logic        m_enable_line;
    logic        m_busy_res;
    logic        m_rejected;

    // predicted sequencer state and timing registers
    phase_t      seq_phase;
    logic [15:0] seq_cnt;
    logic [7:0]  seq_byte;
    logic        seq_rs;
    logic        seq_low;
    logic [2:0]  seq_step;
    logic [3:0]  seq_nib;
    logic [7:0]  cfg_en;
    logic [11:0] cfg_gap;
    logic [15:0] cfg_pu;
    logic [15:0] cfg_clr;

    lcd_levels_t lcd_expect_q[$];
    lcd_levels_t want_levels;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b1;

    char_lcd_nibble_writer uut (.*);

    always #2 aclk = ~aclk;

    // timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // zero durations behave as one tick
    function automatic logic [15:0] dur_or_one(input logic [15:0] v);
        return (v == 16'd0) ? 16'd1 : v;
    endfunction

    // begin a byte with the high nibble on the lines
    function automatic void load_byte(input logic [7:0] b, input logic rs);
        seq_byte  = b;
        seq_rs    = rs;
        seq_low   = 1'b0;
        seq_nib   = b[7:4];
        seq_phase = PH_EN_HIGH;
        seq_cnt   = dur_or_one({8'd0, cfg_en});
    endfunction

    // one tick of the controller: accept the request, show lines, then count down
    function automatic lcd_levels_t lcd_tick(input op_t op, input logic [7:0] b);
        lcd_levels_t r;
        r.rej = 1'b0;
        if (op != OP_TICK) begin
            if (seq_phase != PH_IDLE) begin
                r.rej = 1'b1;
            end else if (op == OP_CMD) begin
                seq_step = STEP_NONE;
                load_byte(b, 1'b0);
            end else if (op == OP_DATA) begin
                seq_step = STEP_NONE;
                load_byte(b, 1'b1);
            end else begin
                seq_step  = STEP_NONE;
                seq_phase = PH_POWERUP;
                seq_cnt   = dur_or_one(cfg_pu);
            end
        end
        r.nibble = seq_nib;
        r.rs     = seq_rs;
        r.en     = (seq_phase == PH_EN_HIGH);
        r.busy   = (seq_phase != PH_IDLE);

        if (seq_phase != PH_IDLE) begin
            if (seq_cnt > 16'd1) begin
                seq_cnt = seq_cnt - 16'd1;
            end else begin
                seq_cnt = 16'd0;
                case (seq_phase)
                    PH_POWERUP: begin
                        seq_step = STEP_FIRST;
                        load_byte(INIT_CMDS[7:0], 1'b0);
                    end
                    PH_EN_HIGH: begin
                        seq_phase = PH_GAP;
                        seq_cnt   = dur_or_one({4'd0, cfg_gap});
                    end
                    PH_GAP: begin
                        if (!seq_low) begin
                            seq_low   = 1'b1;
                            seq_nib   = seq_byte[3:0];
                            seq_phase = PH_EN_HIGH;
                            seq_cnt   = dur_or_one({8'd0, cfg_en});
                        end else if (seq_step == STEP_CLEAR) begin
                            seq_phase = PH_CLEAR_WAIT;
                            seq_cnt   = dur_or_one(cfg_clr);
                        end else if (seq_step == STEP_NONE || seq_step >= STEP_LAST) begin
                            seq_step  = STEP_NONE;
                            seq_phase = PH_IDLE;
                        end else begin
                            seq_step = seq_step + 3'd1;
                            load_byte(INIT_CMDS[8*(seq_step-1) +: 8], 1'b0);
                        end
                    end
                    default: begin
                        seq_step = STEP_LAST;
                        load_byte(INIT_CMDS[47:40], 1'b0);
                    end
                endcase
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
                 what, got, want, cycle_count);
    endtask

    // send one word, entered and left at a falling edge
    task automatic send_word(input op_t op, input logic [7:0] b);
        while (idle_on && $urandom_range(99) < 28) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_byte_in <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        lcd_expect_q.push_back(lcd_tick(op, b));
        @(negedge aclk);
    endtask

    // tick until the sequencer is idle, then let every word come out
    task automatic settle_idle();
        while (seq_phase != PH_IDLE) send_word(OP_TICK, 8'($urandom_range(255)));
        s_valid <= 1'b0;
        while (lcd_expect_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // apb write: setup phase, access phase, then idle
    task automatic apb_write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_EN_HIGH: cfg_en  = val[7:0];
            REG_GAP:     cfg_gap = val[11:0];
            REG_POWERUP: cfg_pu  = val[15:0];
            REG_CLEAR:   cfg_clr = val[15:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // reset timing: a command byte with busy drops
    task automatic test_default_timing();
        send_word(OP_CMD, 8'h00);
        send_word(OP_DATA, 8'hFF);
        send_word(OP_INIT, 8'hFF);
        send_word(OP_CMD, 8'h12);
        settle_idle();
        send_word(OP_TICK, 8'hFF);
        settle_idle();
    endtask

    // all durations written as zero act as one tick
    task automatic test_zero_durations();
        apb_write_reg(REG_EN_HIGH, 32'd0);
        apb_write_reg(REG_GAP, 32'd0);
        apb_write_reg(REG_POWERUP, 32'd0);
        apb_write_reg(REG_CLEAR, 32'd0);
        send_word(OP_CMD, 8'hA5);
        // keep asking until a request lands right as the byte ends
        while (seq_phase != PH_IDLE) send_word(OP_DATA, 8'h5A);
        send_word(OP_DATA, 8'h5A);
        settle_idle();
        send_word(OP_INIT, 8'h00);
        settle_idle();
    endtask

    // longest enable strobe, then an init with short waits and byte ignored
    task automatic test_max_durations();
        apb_write_reg(REG_EN_HIGH, 32'd255);
        apb_write_reg(REG_GAP, 32'd1);
        send_word(OP_DATA, 8'h81);
        settle_idle();
        apb_write_reg(REG_EN_HIGH, 32'd1);
        apb_write_reg(REG_GAP, 32'd1);
        apb_write_reg(REG_POWERUP, 32'd60);
        apb_write_reg(REG_CLEAR, 32'd40);
        send_word(OP_INIT, 8'h7E);
        settle_idle();
    endtask

    // random requests over short random timings, rewritten every segment
    task automatic test_random_traffic();
        int   n;
        int   pick;
        op_t  op;
        for (n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 250 == 0) begin
                settle_idle();
                apb_write_reg(REG_EN_HIGH, ($urandom & 32'hFFFF_FF00) | $urandom_range(4));
                apb_write_reg(REG_GAP, ($urandom & 32'hFFFF_F000) | $urandom_range(8));
                apb_write_reg(REG_POWERUP, ($urandom & 32'hFFFF_0000) | $urandom_range(40));
                apb_write_reg(REG_CLEAR, ($urandom & 32'hFFFF_0000) | $urandom_range(40));
            end
            idle_on = !(n >= 300 && n < 550);
            pick = $urandom_range(99);
            if (pick < 50)
                op = OP_TICK;
            else if (pick < 72)
                op = OP_CMD;
            else if (pick < 94)
                op = OP_DATA;
            else
                op = OP_INIT;
            send_word(op, 8'($urandom_range(255)));
        end
        idle_on = 1'b1;
        settle_idle();
    endtask

    // result side backpressure
    always @(negedge aclk) begin
        m_ready <= !idle_on || ($urandom_range(99) >= 28);
    end

    // compare each word leaving the block with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (lcd_expect_q.size() == 0) begin
                note_mismatch("word with nothing expected", 0, 0);
            end else begin
                want_levels = lcd_expect_q.pop_front();
                if (m_data_nibble !== want_levels.nibble)
                    note_mismatch("data_nibble", int'(m_data_nibble),
                                  int'(want_levels.nibble));
                if (m_reg_select !== want_levels.rs)
                    note_mismatch("reg_select", int'(m_reg_select), int'(want_levels.rs));
                if (m_enable_line !== want_levels.en)
                    note_mismatch("enable_line", int'(m_enable_line), int'(want_levels.en));
                if (m_busy_res !== want_levels.busy)
                    note_mismatch("busy_res", int'(m_busy_res), int'(want_levels.busy));
                if (m_rejected !== want_levels.rej)
                    note_mismatch("rejected", int'(m_rejected), int'(want_levels.rej));
            end
        end
    end

    initial begin
        aresetn   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = 4'd0;
        pwdata    = 32'd0;
        s_valid   = 1'b0;
        s_opcode  = OP_TICK;
        s_byte_in = 8'd0;
        m_ready   = 1'b0;

        seq_phase = PH_IDLE;
        seq_cnt   = 16'd0;
        seq_byte  = 8'd0;
        seq_rs    = 1'b0;
        seq_low   = 1'b0;
        seq_step  = STEP_NONE;
        seq_nib   = 4'd0;
        cfg_en    = EN_HIGH_RST;
        cfg_gap   = GAP_RST;
        cfg_pu    = POWERUP_RST;
        cfg_clr   = CLEAR_RST;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_timing();
        test_zero_durations();
        test_max_durations();
        test_random_traffic();

        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && lcd_expect_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
